// ----- rtl/frn_pkg.sv -----
// fasta residue normaliser: shared constants, command/status types and residue mapping
// no dependencies; imported by every module of the block
`default_nettype none

package frn_pkg;

  // default configuration of the top level
  localparam int MAX_HELD_BLANKS_DEF = 62;
  localparam int LENGTH_BITS_DEF     = 32;

  // result kinds
  localparam logic [1:0] KIND_RESIDUE  = 2'd0;
  localparam logic [1:0] KIND_GENE_END = 2'd1;
  localparam logic [1:0] KIND_SUMMARY  = 2'd2;

  // input actions
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // sequence alphabets
  localparam logic SEQ_PROTEIN    = 1'b0;
  localparam logic SEQ_NUCLEOTIDE = 1'b1;

  // special characters
  localparam logic [7:0] CH_NL      = 8'd10;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_VT      = 8'd11;
  localparam logic [7:0] CH_FF      = 8'd12;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_STAR    = "*";
  localparam logic [7:0] CH_DASH    = "-";
  localparam logic [7:0] CH_HEADER  = ">";
  localparam logic [7:0] CH_COMMENT = ";";
  localparam logic [7:0] CH_LOW_LO  = 8'd97;
  localparam logic [7:0] CH_LOW_HI  = 8'd123;
  localparam logic [7:0] CASE_DIFF  = 8'd32;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic emit_pend;
    logic emit_blank;
    logic emit_gend;
    logic emit_sum;
    logic run_last;
  } frn_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic dec_take;
    logic dec_close;
    logic dec_end;
    logic snap_valid;
    logic plan_take;
    logic plan_sum;
    logic held_nz;
    logic held_one;
    logic slot_free;
  } frn_stat_t;

  // blank test: space, tab, cr, vt, ff
  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) ||
           (c == CH_VT) || (c == CH_FF);
  endfunction

  // case fold and reduce to the selected alphabet
  function automatic logic [6:0] map_residue(input logic [7:0] c, input logic nuc);
    logic [7:0] u;
    logic [7:0] r;
    u = ((c >= CH_LOW_LO) && (c < CH_LOW_HI)) ? c - CASE_DIFF : c;
    r = "A";
    if (!c[7]) begin
      if (nuc == SEQ_PROTEIN) begin
        case (u)
          "A", "C", "D", "E", "F", "G", "H", "I", "K", "L",
          "M", "N", "P", "Q", "R", "S", "T", "V", "W", "Y": r = u;
          "B": r = "D";
          "U": r = "C";
          "X": r = "G";
          "Z": r = "E";
          default: r = "A";
        endcase
      end else begin
        case (u)
          "A", "C", "G", "T": r = u;
          "U", "Y", "K", "B": r = "T";
          "S": r = "C";
          default: r = "A";
        endcase
      end
    end
    return r[6:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/frn_channels.sv -----
// fasta residue normaliser: valid/ready channel interfaces for input, result and config
// no dependencies
`default_nettype none

// input byte channel
interface frn_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;
  modport source (output valid, output action, output data_byte, input ready);
  modport sink   (input valid, input action, input data_byte, output ready);
endinterface

// result channel
interface frn_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [6:0]  symbol;
  logic        gene_first;
  logic [31:0] count_value;
  logic        no_genes;
  logic        run_last;
  modport source (output valid, output kind, output symbol, output gene_first,
                  output count_value, output no_genes, output run_last, input ready);
  modport sink   (input valid, input kind, input symbol, input gene_first,
                  input count_value, input no_genes, input run_last, output ready);
endinterface

// configuration write channel
interface frn_cfg_if;
  logic valid;
  logic ready;
  logic seq_kind;
  modport source (output valid, output seq_kind, input ready);
  modport sink   (input valid, input seq_kind, output ready);
endinterface

`default_nettype wire

// ----- rtl/frn_ctrl.sv -----
// fasta residue normaliser: controller sequencing the results of one transaction
// depends on frn_pkg for command and status types
`default_nettype none

module frn_ctrl
  import frn_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire frn_stat_t stat,
  output frn_cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PEND,
    ST_BLANK,
    ST_GEND,
    ST_SUM
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // ready only between transactions
  assign in_ready = (state_r == ST_IDLE);

  // next state and emit strobes
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          if (stat.dec_take || stat.dec_close) begin
            state_nxt = ST_PEND;
          end else if (stat.dec_end) begin
            state_nxt = ST_SUM;
          end
        end
      end
      ST_PEND: begin
        if (!stat.snap_valid || stat.slot_free) begin
          cmd.emit_pend = stat.snap_valid;
          cmd.run_last  = stat.plan_take && !stat.held_nz;
          if (stat.plan_take) begin
            state_nxt = stat.held_nz ? ST_BLANK : ST_IDLE;
          end else begin
            state_nxt = ST_GEND;
          end
        end
      end
      ST_BLANK: begin
        if (stat.slot_free) begin
          cmd.emit_blank = 1'b1;
          cmd.run_last   = stat.held_one;
          if (stat.held_one) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_GEND: begin
        if (stat.slot_free) begin
          cmd.emit_gend = 1'b1;
          cmd.run_last  = !stat.plan_sum;
          state_nxt     = stat.plan_sum ? ST_SUM : ST_IDLE;
        end
      end
      ST_SUM: begin
        if (stat.slot_free) begin
          cmd.emit_sum = 1'b1;
          cmd.run_last = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/frn_dpath.sv -----
// fasta residue normaliser: parser state, counters, residue mapping and result register
// depends on frn_pkg for constants, types and the mapping function
`default_nettype none

module frn_dpath
  import frn_pkg::*;
#(
  parameter int MAX_HELD_BLANKS = MAX_HELD_BLANKS_DEF,
  parameter int LENGTH_BITS     = LENGTH_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_action,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       cfg_valid,
  input  wire logic       cfg_seq_kind,
  input  wire frn_cmd_t   cmd,
  output frn_stat_t       stat,
  input  wire logic       out_ready,
  output logic            out_valid,
  output logic [1:0]      out_kind,
  output logic [6:0]      out_symbol,
  output logic            out_gene_first,
  output logic [31:0]     out_count_value,
  output logic            out_no_genes,
  output logic            out_run_last
);

  localparam int HELD_W = $clog2(MAX_HELD_BLANKS + 1);

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_SKIP  = 2'd1,
    MODE_SEQ   = 2'd2
  } mode_t;

  typedef logic [LENGTH_BITS-1:0] len_t;

  // parser state
  logic              seq_kind_r;
  mode_t             mode_r;
  logic [HELD_W-1:0] held_r;
  logic              pend_valid_r;
  logic [7:0]        pend_char_r;
  logic              gene_open_r;
  logic              gene_any_r;
  logic              hdr_seen_r;
  len_t              gene_len_r;
  len_t              total_len_r;

  // per-transaction plan
  logic       snap_valid_r;
  logic [7:0] snap_char_r;
  logic       plan_take_r;
  logic       plan_sum_r;
  logic       plan_nog_r;

  // result register
  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [6:0]  out_symbol_r;
  logic        out_first_r;
  logic [31:0] out_count_r;
  logic        out_nog_r;
  logic        out_last_r;

  logic dec_blank;
  logic dec_byte;
  logic dec_take;
  logic dec_hdr;
  logic dec_close;
  logic dec_end;
  logic snap_keep;
  logic emit_res;
  logic emit_any;
  logic slot_free;

  // saturating increment of a length counter
  function automatic len_t sat_inc(input len_t v);
    return (v == '1) ? v : v + len_t'(1);
  endfunction

  // clip a length counter to the 32 bit result field
  function automatic logic [31:0] clip32(input len_t v);
    logic [63:0] w;
    w = 64'(v);
    return (|w[63:32]) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

  // decode the offered byte against the line state
  always_comb begin
    dec_blank = is_blank(in_data_byte);
    dec_end   = (in_action == ACT_END);
    dec_byte  = (in_action == ACT_BYTE) && (in_data_byte != CH_NL);
    dec_take  = dec_byte && !dec_blank &&
                ((mode_r == MODE_SEQ) ||
                 ((mode_r == MODE_START) && gene_open_r &&
                  (in_data_byte != CH_COMMENT) && (in_data_byte != CH_HEADER)));
    dec_hdr   = dec_byte && (mode_r == MODE_START) && (in_data_byte == CH_HEADER);
    dec_close = (dec_end || dec_hdr) && gene_open_r;
    snap_keep = dec_take ? pend_valid_r
                         : (dec_close && pend_valid_r &&
                            (pend_char_r != CH_STAR) && (pend_char_r != CH_DASH));
  end

  assign emit_res  = cmd.emit_pend || cmd.emit_blank;
  assign emit_any  = emit_res || cmd.emit_gend || cmd.emit_sum;
  assign slot_free = !out_valid_r || out_ready;

  // status towards the controller
  always_comb begin
    stat            = '0;
    stat.dec_take   = dec_take;
    stat.dec_close  = dec_close;
    stat.dec_end    = dec_end;
    stat.snap_valid = snap_valid_r;
    stat.plan_take  = plan_take_r;
    stat.plan_sum   = plan_sum_r;
    stat.held_nz    = (held_r != '0);
    stat.held_one   = (held_r == HELD_W'(1));
    stat.slot_free  = slot_free;
  end

  // parser state and plan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_kind_r   <= SEQ_PROTEIN;
      mode_r       <= MODE_START;
      held_r       <= '0;
      pend_valid_r <= 1'b0;
      pend_char_r  <= '0;
      gene_open_r  <= 1'b0;
      gene_any_r   <= 1'b0;
      hdr_seen_r   <= 1'b0;
      gene_len_r   <= '0;
      total_len_r  <= '0;
      snap_valid_r <= 1'b0;
      snap_char_r  <= '0;
      plan_take_r  <= 1'b0;
      plan_sum_r   <= 1'b0;
      plan_nog_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        seq_kind_r <= cfg_seq_kind;
      end
      if (cmd.accept) begin
        snap_valid_r <= snap_keep;
        snap_char_r  <= pend_char_r;
        plan_take_r  <= dec_take;
        plan_sum_r   <= dec_end;
        plan_nog_r   <= !hdr_seen_r;
        // line state
        if (dec_end || ((in_action == ACT_BYTE) && (in_data_byte == CH_NL))) begin
          mode_r <= MODE_START;
          held_r <= '0;
        end else if (mode_r == MODE_START) begin
          if (dec_take) begin
            mode_r <= MODE_SEQ;
          end else if (!dec_blank) begin
            mode_r <= MODE_SKIP;
          end
        end else if ((mode_r == MODE_SEQ) && dec_blank) begin
          if (held_r < HELD_W'(MAX_HELD_BLANKS)) begin
            held_r <= held_r + HELD_W'(1);
          end
        end
        // held residue
        if (dec_take) begin
          pend_valid_r <= 1'b1;
          pend_char_r  <= in_data_byte;
        end else if (dec_close || dec_end) begin
          pend_valid_r <= 1'b0;
          pend_char_r  <= '0;
        end
        // gene bookkeeping
        if (dec_hdr) begin
          gene_open_r <= 1'b1;
          hdr_seen_r  <= 1'b1;
        end else if (dec_end) begin
          gene_open_r <= 1'b0;
          hdr_seen_r  <= 1'b0;
        end
      end else if (cmd.emit_blank) begin
        held_r <= held_r - HELD_W'(1);
      end
      // counters follow the emitted results
      if (emit_res) begin
        gene_any_r  <= 1'b1;
        gene_len_r  <= sat_inc(gene_len_r);
        total_len_r <= sat_inc(total_len_r);
      end else if (cmd.emit_gend) begin
        gene_any_r <= 1'b0;
        gene_len_r <= '0;
      end else if (cmd.emit_sum) begin
        gene_any_r  <= 1'b0;
        gene_len_r  <= '0;
        total_len_r <= '0;
      end
    end
  end

  // result register valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_any) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (emit_any) begin
      out_last_r  <= cmd.run_last;
      out_first_r <= emit_res && !gene_any_r;
      priority if (cmd.emit_pend) begin
        out_kind_r   <= KIND_RESIDUE;
        out_symbol_r <= map_residue(snap_char_r, seq_kind_r);
        out_count_r  <= '0;
        out_nog_r    <= 1'b0;
      end else if (cmd.emit_blank) begin
        out_kind_r   <= KIND_RESIDUE;
        out_symbol_r <= map_residue(CH_SPACE, seq_kind_r);
        out_count_r  <= '0;
        out_nog_r    <= 1'b0;
      end else if (cmd.emit_gend) begin
        out_kind_r   <= KIND_GENE_END;
        out_symbol_r <= '0;
        out_count_r  <= clip32(gene_len_r);
        out_nog_r    <= 1'b0;
      end else begin
        out_kind_r   <= KIND_SUMMARY;
        out_symbol_r <= '0;
        out_count_r  <= clip32(total_len_r);
        out_nog_r    <= plan_nog_r;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_symbol      = out_symbol_r;
  assign out_gene_first  = out_first_r;
  assign out_count_value = out_count_r;
  assign out_no_genes    = out_nog_r;
  assign out_run_last    = out_last_r;

endmodule

`default_nettype wire

// ----- rtl/fasta_residue_normalizer.sv -----
// fasta residue normaliser top level over frn_ctrl and frn_dpath (frn_pkg, frn_channels)
// one transaction at a time: the input is ready only while the controller is idle, and the
// results of a transaction leave one by one through the single result register, which is
// loaded at most once a cycle and holds its result while the output stalls
// each result is registered in the result register before it is valid on the output
// reset: synchronous active-low rst_n clears parser state, counters and seq_kind (protein)
`default_nettype none

module fasta_residue_normalizer
  import frn_pkg::*;
#(
  parameter int MAX_HELD_BLANKS = MAX_HELD_BLANKS_DEF,
  parameter int LENGTH_BITS     = LENGTH_BITS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  frn_in_if.sink    in_ch,
  frn_out_if.source out_ch,
  frn_cfg_if.sink   cfg_ch
);

  frn_cmd_t  cmd;
  frn_stat_t stat;
  logic      in_ready;

  // configuration writes are always taken
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  // controller
  frn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  frn_dpath #(
    .MAX_HELD_BLANKS (MAX_HELD_BLANKS),
    .LENGTH_BITS     (LENGTH_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_action       (in_ch.action),
    .in_data_byte    (in_ch.data_byte),
    .cfg_valid       (cfg_ch.valid),
    .cfg_seq_kind    (cfg_ch.seq_kind),
    .cmd             (cmd),
    .stat            (stat),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_kind        (out_ch.kind),
    .out_symbol      (out_ch.symbol),
    .out_gene_first  (out_ch.gene_first),
    .out_count_value (out_ch.count_value),
    .out_no_genes    (out_ch.no_genes),
    .out_run_last    (out_ch.run_last)
  );

endmodule

`default_nettype wire

// ----- bench/tb_fasta_residue_normalizer.sv -----
`timescale 1ns / 1ps
// testbench for fasta_residue_normalizer: a directed table, then random fasta files
// checked against a behavioural normaliser held inside the bench
// depends on frn_pkg, frn_channels and the fasta_residue_normalizer rtl

module tb_fasta_residue_normalizer;
  import frn_pkg::*;

  localparam int HELD_MAX      = 62;
  localparam int BURST_MAX     = 63;
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 40;
  localparam int REPORT_MAX    = 10;

  typedef enum logic [1:0] {LS_START, LS_SKIP, LS_SEQ} line_state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  symbol;
    logic        gene_first;
    logic [31:0] count_value;
    logic        no_genes;
    logic        run_last;
  } norm_result_t;

  typedef struct packed {
    logic         act;
    logic [7:0]   b;
    logic         typed;
    norm_result_t want;
  } dir_row_t;

  typedef struct packed {
    logic       act;
    logic [7:0] b;
  } file_item_t;

  localparam norm_result_t UNTYPED = '0;

  logic clk;
  logic rst_n;

  frn_in_if  in_if ();
  frn_out_if out_if ();
  frn_cfg_if cfg_if ();

  fasta_residue_normalizer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // clock, 4 ns period
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // directed table; typed rows carry the single result they must give
  dir_row_t dir_rows [0:22] = '{
    '{ACT_END,  8'h00,   1'b1,
      norm_result_t'{KIND_SUMMARY, 7'd0, 1'b0, 32'd0, 1'b1, 1'b1}},  // nothing seen yet
    '{ACT_BYTE, "a",     1'b0, UNTYPED},  // sequence text before any header
    '{ACT_BYTE, CH_NL,   1'b0, UNTYPED},
    '{ACT_BYTE, ";",     1'b0, UNTYPED},  // comment line
    '{ACT_BYTE, ">",     1'b0, UNTYPED},  // header mark inside a comment
    '{ACT_BYTE, CH_NL,   1'b0, UNTYPED},
    '{ACT_BYTE, ">",     1'b0, UNTYPED},  // first gene opens
    '{ACT_BYTE, CH_NL,   1'b0, UNTYPED},
    '{ACT_BYTE, ">",     1'b1,
      norm_result_t'{KIND_GENE_END, 7'd0, 1'b0, 32'd0, 1'b0, 1'b1}},  // empty gene
    '{ACT_BYTE, CH_NL,   1'b0, UNTYPED},
    '{ACT_BYTE, CH_TAB,  1'b0, UNTYPED},  // leading blank
    '{ACT_BYTE, "b",     1'b0, UNTYPED},
    '{ACT_BYTE, " ",     1'b0, UNTYPED},  // interior blank held
    '{ACT_BYTE, 8'hFF,   1'b0, UNTYPED},  // top byte value
    '{ACT_BYTE, "u",     1'b0, UNTYPED},
    '{ACT_BYTE, "*",     1'b0, UNTYPED},  // star not at gene end
    '{ACT_BYTE, CH_NL,   1'b0, UNTYPED},
    '{ACT_BYTE, 8'h00,   1'b0, UNTYPED},  // bottom byte value
    '{ACT_BYTE, "-",     1'b0, UNTYPED},
    '{ACT_BYTE, 8'h7F,   1'b0, UNTYPED},
    '{ACT_BYTE, "-",     1'b0, UNTYPED},  // trailing dash, dropped at close
    '{ACT_END,  8'hFF,   1'b0, UNTYPED},
    '{ACT_BYTE, "X",     1'b0, UNTYPED}   // after end: no gene open
  };

  // behavioural normaliser state
  logic         nz_kind;
  line_state_e  nz_line;
  int unsigned  nz_held;
  logic         nz_pend_v;
  logic [7:0]   nz_pend_c;
  logic         nz_gene_open;
  logic         nz_gene_any;
  logic         nz_header_seen;
  logic [31:0]  nz_gene_len;
  logic [31:0]  nz_total_len;
  norm_result_t step_results [$];
  norm_result_t exp_stream [$];

  file_item_t   file_items [$];

  // run bookkeeping
  bit          tx_calm;
  bit          rx_calm;
  int unsigned rx_hold;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned residues_seen = 0;
  int unsigned gene_ends_seen = 0;
  int unsigned summaries_seen = 0;
  int unsigned full_bursts = 0;
  int unsigned kind_writes = 0;
  norm_result_t got_res;
  norm_result_t want_res;

  function automatic void clear_parser();
    nz_line        = LS_START;
    nz_held        = 0;
    nz_pend_v      = 1'b0;
    nz_pend_c      = 8'd0;
    nz_gene_open   = 1'b0;
    nz_gene_any    = 1'b0;
    nz_header_seen = 1'b0;
    nz_gene_len    = 32'd0;
    nz_total_len   = 32'd0;
  endfunction

  function automatic logic is_gap_byte(input logic [7:0] c);
    case (c)
      CH_SPACE, CH_TAB, CH_CR, CH_VT, CH_FF: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // case fold, keep alphabet members, reduce the rest
  function automatic logic [6:0] fold_residue(input logic [7:0] c);
    string      keep_set;
    logic [7:0] u;
    logic [7:0] r;
    logic       found;
    r     = "A";
    found = 1'b0;
    if (!c[7]) begin
      u = (c >= 8'd97 && c < 8'd123) ? c - 8'd32 : c;
      keep_set = (nz_kind == SEQ_PROTEIN) ? "ACDEFGHIKLMNPQRSTVWY" : "ACGT";
      for (int i = 0; i < keep_set.len(); i++)
        if (keep_set[i] == u) found = 1'b1;
      if (found) begin
        r = u;
      end else if (nz_kind == SEQ_PROTEIN) begin
        if (u == "B") r = "D";
        else if (u == "U") r = "C";
        else if (u == "X") r = "G";
        else if (u == "Z") r = "E";
      end else begin
        if (u == "U" || u == "Y" || u == "K" || u == "B") r = "T";
        else if (u == "S") r = "C";
      end
    end
    return r[6:0];
  endfunction

  function automatic void push_result(input logic [1:0] kind, input logic [6:0] sym,
                                      input logic first, input logic [31:0] cnt,
                                      input logic nog);
    if (step_results.size() < BURST_MAX)
      step_results.push_back(norm_result_t'{kind, sym, first, cnt, nog, 1'b0});
  endfunction

  function automatic void push_residue(input logic [7:0] raw);
    push_result(KIND_RESIDUE, fold_residue(raw), !nz_gene_any, 32'd0, 1'b0);
    nz_gene_any = 1'b1;
    if (nz_gene_len != '1) nz_gene_len++;
    if (nz_total_len != '1) nz_total_len++;
  endfunction

  // flush the held residue unless it is a stop or gap mark, then the gene end
  function automatic void finish_gene();
    if (!nz_gene_open) return;
    if (nz_pend_v && nz_pend_c != CH_STAR && nz_pend_c != CH_DASH)
      push_residue(nz_pend_c);
    push_result(KIND_GENE_END, 7'd0, 1'b0, nz_gene_len, 1'b0);
    nz_gene_open = 1'b0;
    nz_gene_any  = 1'b0;
    nz_pend_v    = 1'b0;
    nz_pend_c    = 8'd0;
    nz_gene_len  = 32'd0;
  endfunction

  function automatic void accept_residue(input logic [7:0] c);
    if (nz_pend_v) push_residue(nz_pend_c);
    while (nz_held > 0) begin
      push_residue(CH_SPACE);
      nz_held--;
    end
    nz_pend_c = c;
    nz_pend_v = 1'b1;
  endfunction

  // results of one input transaction, left in step_results
  function automatic void normalize_byte(input logic act, input logic [7:0] c);
    norm_result_t tail;
    step_results.delete();
    if (act == ACT_END) begin
      finish_gene();
      push_result(KIND_SUMMARY, 7'd0, 1'b0, nz_total_len, !nz_header_seen);
      clear_parser();
    end else if (c == CH_NL) begin
      nz_held = 0;
      nz_line = LS_START;
    end else begin
      case (nz_line)
        LS_START: begin
          if (is_gap_byte(c)) begin
          end else if (c == CH_COMMENT) begin
            nz_line = LS_SKIP;
          end else if (c == CH_HEADER) begin
            finish_gene();
            nz_gene_open   = 1'b1;
            nz_header_seen = 1'b1;
            nz_line        = LS_SKIP;
          end else if (nz_gene_open) begin
            nz_line = LS_SEQ;
            accept_residue(c);
          end else begin
            nz_line = LS_SKIP;
          end
        end
        LS_SEQ: begin
          if (is_gap_byte(c)) begin
            if (nz_held < HELD_MAX) nz_held++;
          end else begin
            accept_residue(c);
          end
        end
        default: begin
        end
      endcase
    end
    if (step_results.size() != 0) begin
      tail = step_results[step_results.size() - 1];
      tail.run_last = 1'b1;
      step_results[step_results.size() - 1] = tail;
    end
    if (step_results.size() == BURST_MAX) full_bursts++;
  endfunction

  // idle length: mostly none, some short, a few long
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_item(input logic act, input logic [7:0] b, input logic typed,
                           input norm_result_t want);
    int unsigned gap;
    gap = pick_gap(tx_calm);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.action    <= act;
    in_if.data_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    normalize_byte(act, b);
    if (typed) exp_stream.push_back(want);
    else foreach (step_results[i]) exp_stream.push_back(step_results[i]);
    items_sent++;
  endtask

  // hold the sender until every expected result is back, then let the block settle
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (exp_stream.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_kind(input logic v);
    wait_drained();
    cfg_if.valid    <= 1'b1;
    cfg_if.seq_kind <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    nz_kind = v;
    kind_writes++;
  endtask

  // random fasta building blocks
  function automatic void add_byte(input logic [7:0] b);
    file_items.push_back(file_item_t'{ACT_BYTE, b});
  endfunction

  function automatic void add_blanks(input int unsigned n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0: b = CH_TAB;
        1: b = CH_CR;
        2: b = CH_VT;
        3: b = CH_FF;
        default: b = CH_SPACE;
      endcase
      add_byte(b);
    end
  endfunction

  function automatic void add_text(input int unsigned n);
    for (int i = 0; i < n; i++) add_byte(8'($urandom_range(33, 126)));
  endfunction

  function automatic logic [7:0] pick_residue();
    string       prot_pool;
    string       nuc_pool;
    logic [7:0]  b;
    int unsigned r;
    prot_pool = "ACDEFGHIKLMNPQRSTVWYBUXZJO";
    nuc_pool  = "ACGTURYKMSWBDHVNX";
    r = $urandom_range(0, 99);
    if (r < 40) begin
      b = prot_pool[$urandom_range(0, prot_pool.len() - 1)];
    end else if (r < 70) begin
      b = nuc_pool[$urandom_range(0, nuc_pool.len() - 1)];
    end else if (r < 85) begin
      b = nuc_pool[$urandom_range(0, nuc_pool.len() - 1)] | 8'h20;
    end else if (r < 95) begin
      do b = 8'($urandom_range(0, 255)); while (b == CH_NL);
    end else begin
      b = $urandom_range(0, 1) ? CH_STAR : CH_DASH;
    end
    return b;
  endfunction

  // one sequence line, optionally with a long blank run that may saturate the held count
  function automatic void add_seq_line(input bit long_run);
    int unsigned n;
    if ($urandom_range(0, 3) == 0) add_blanks($urandom_range(1, 2));
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++) begin
      add_byte(pick_residue());
      if (i + 1 < n) begin
        if (long_run && i == 0) add_blanks($urandom_range(60, 70));
        else if ($urandom_range(0, 99) < 15) add_blanks($urandom_range(1, 3));
      end
    end
    if ($urandom_range(0, 9) < 3) add_blanks($urandom_range(1, 3));
    add_byte(CH_NL);
  endfunction

  // noise line: any byte values, newline included
  function automatic void add_noise();
    int unsigned n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)));
    add_byte(CH_NL);
  endfunction

  function automatic void build_file(input bit force_long);
    int unsigned genes;
    int unsigned lines;
    int unsigned r;
    bit          long_pending;
    logic [7:0]  tail_b;
    file_items.delete();
    long_pending = force_long;
    if ($urandom_range(0, 4) == 0) begin
      if ($urandom_range(0, 1)) add_noise();
      else add_seq_line(1'b0);
    end
    genes = $urandom_range(1, 3);
    for (int g = 0; g < genes; g++) begin
      if ($urandom_range(0, 5) == 0) add_blanks($urandom_range(1, 2));
      add_byte(CH_HEADER);
      add_text($urandom_range(0, 6));
      add_byte(CH_NL);
      lines = $urandom_range(0, 3);
      for (int l = 0; l < lines; l++) begin
        r = $urandom_range(0, 19);
        if (r == 0) begin
          add_blanks($urandom_range(0, 1));
          add_byte(CH_COMMENT);
          add_text($urandom_range(0, 5));
          add_byte(CH_NL);
        end else if (r == 1) begin
          add_blanks($urandom_range(0, 2));
          add_byte(CH_NL);
        end else if (r == 2) begin
          add_noise();
        end else begin
          add_seq_line(long_pending || ($urandom_range(0, 99) == 0));
          long_pending = 1'b0;
        end
      end
    end
    if ($urandom_range(0, 3) != 0) begin
      // sometimes the last line runs straight into the end, held blanks included
      if ($urandom_range(0, 2) == 0 && file_items.size() != 0 &&
          file_items[file_items.size() - 1].b == CH_NL) begin
        file_items.delete(file_items.size() - 1);
        if ($urandom_range(0, 1)) add_blanks($urandom_range(1, 3));
      end
      tail_b = 8'($urandom_range(0, 255));
      file_items.push_back(file_item_t'{ACT_END, tail_b});
    end
  endfunction

  function automatic void note_mismatch(input string what, input norm_result_t want,
                                        input norm_result_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("mismatch (%s): exp kind=%0d sym=%0d first=%0d cnt=%0d nog=%0d last=%0d",
               what, want.kind, want.symbol, want.gene_first, want.count_value,
               want.no_genes, want.run_last,
               "\n          got kind=%0d sym=%0d first=%0d cnt=%0d nog=%0d last=%0d",
               got.kind, got.symbol, got.gene_first, got.count_value,
               got.no_genes, got.run_last);
  endfunction

  // result sink with random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      rx_hold      <= 0;
    end else if (rx_hold != 0) begin
      out_if.ready <= 1'b0;
      rx_hold      <= rx_hold - 1;
    end else begin
      out_if.ready <= 1'b1;
      rx_hold      <= pick_gap(rx_calm);
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      got_res = norm_result_t'{out_if.kind, out_if.symbol, out_if.gene_first,
                               out_if.count_value, out_if.no_genes, out_if.run_last};
      results_seen++;
      if (exp_stream.size() == 0) begin
        note_mismatch("unexpected result", UNTYPED, got_res);
      end else begin
        want_res = exp_stream.pop_front();
        if (got_res.kind !== want_res.kind || got_res.symbol !== want_res.symbol ||
            got_res.gene_first !== want_res.gene_first ||
            got_res.count_value !== want_res.count_value ||
            got_res.no_genes !== want_res.no_genes ||
            got_res.run_last !== want_res.run_last)
          note_mismatch("field", want_res, got_res);
        case (want_res.kind)
          KIND_RESIDUE:  residues_seen++;
          KIND_GENE_END: gene_ends_seen++;
          default:       summaries_seen++;
        endcase
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("fasta_residue_normalizer verification failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic        phase_kind;
    int unsigned phase_items;
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.action     = ACT_BYTE;
    in_if.data_byte  = 8'd0;
    cfg_if.valid     = 1'b0;
    cfg_if.seq_kind  = SEQ_PROTEIN;
    tx_calm          = 1'b0;
    rx_calm          = 1'b0;
    nz_kind          = SEQ_PROTEIN;
    clear_parser();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table in the protein alphabet
    write_kind(SEQ_PROTEIN);
    foreach (dir_rows[i])
      send_item(dir_rows[i].act, dir_rows[i].b, dir_rows[i].typed, dir_rows[i].want);

    // random files, alphabet switched between phases
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0, 2, 4: phase_kind = SEQ_NUCLEOTIDE;
        3:       phase_kind = 1'($urandom_range(0, 1));
        default: phase_kind = SEQ_PROTEIN;
      endcase
      write_kind(phase_kind);
      tx_calm = (p == 2) || ($urandom_range(0, 3) == 0);
      rx_calm = (p == 2) || ($urandom_range(0, 3) == 0);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        build_file(phase_items == 0 && (p == 1 || p == 4));
        foreach (file_items[i])
          send_item(file_items[i].act, file_items[i].b, 1'b0, UNTYPED);
        phase_items += file_items.size();
        if ($urandom_range(0, 6) == 0) wait_drained();
      end
    end

    wait_drained();
    $display("run covered %0d input transactions, %0d results (%0d residues, %0d gene ends,",
             items_sent, results_seen, residues_seen, gene_ends_seen,
             " %0d summaries), %0d alphabet writes, %0d saturated blank bursts",
             summaries_seen, kind_writes, full_bursts);
    if (mismatches == 0) begin
      $display("fasta_residue_normalizer verification clean");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("fasta_residue_normalizer verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/frn_pkg.sv
rtl/frn_channels.sv
rtl/frn_ctrl.sv
rtl/frn_dpath.sv
rtl/fasta_residue_normalizer.sv
bench/tb_fasta_residue_normalizer.sv
